@@ rtl/dra_pkg.sv @@
package dra_pkg;

  // data path width of the register window
  localparam int unsigned DATA_WIDTH = 32;

  // iteration counter covers one step per quotient bit
  localparam int unsigned CNT_WIDTH = $clog2(DATA_WIDTH);
  localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(DATA_WIDTH - 1);

  // access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // register word offsets
  localparam logic [2:0] OFS_DIVIDEND  = 3'd0;
  localparam logic [2:0] OFS_DIVISOR   = 3'd1;
  localparam logic [2:0] OFS_QUOTIENT  = 3'd2;
  localparam logic [2:0] OFS_REMAINDER = 3'd3;
  localparam logic [2:0] OFS_READY     = 3'd4;
  localparam logic [2:0] OFS_DONE      = 3'd5;

  // ready register value: bit 0 always set
  localparam logic [DATA_WIDTH-1:0] READY_VALUE = DATA_WIDTH'(32'h0000_0001);

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic start;   // accepted word is a divisor write
    logic step;    // one restoring division step
    logic last;    // final step, quotient complete
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_req;   // offered word is a divisor write
    logic out_busy;  // result register full and stalled
  } sts_t;

endpackage

@@ rtl/dra_ctrl.sv @@
module dra_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dra_pkg::sts_t sts_i,
  output dra_pkg::cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DIV  = 1'b1;

  logic                          state_q, state_d;
  logic [dra_pkg::CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                          accept;

  // hold the input side while dividing or while the result is stuck
  assign in_stall_o = (state_q == S_DIV) || sts_i.out_busy;
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.accept = accept;
  assign cmd_o.start  = accept && sts_i.div_req;
  assign cmd_o.step   = (state_q == S_DIV);
  assign cmd_o.last   = (state_q == S_DIV) && (cnt_q == dra_pkg::LAST_STEP);

  // next state and step counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (cmd_o.start) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (cmd_o.last) begin
          state_d = S_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> in_stall_o)
    else $error("input taken during division");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.last |=> (state_q == S_IDLE))
    else $error("division did not end after last step");

  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cnt_q == '0))
    else $error("step counter not cleared in idle");

  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == S_DIV) && (cnt_q == '0))
    else $error("divisor write did not start division");
`endif

endmodule

@@ rtl/dra_datapath.sv @@
module dra_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           kind_i,
  input  logic [2:0]                     reg_offset_i,
  input  logic [dra_pkg::DATA_WIDTH-1:0] write_data_i,
  input  dra_pkg::cmd_t                  cmd_i,
  output dra_pkg::sts_t                  sts_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dra_pkg::DATA_WIDTH-1:0] read_data_o
);

  localparam int unsigned W = dra_pkg::DATA_WIDTH;

  logic [W-1:0] dividend_q;
  logic [W-1:0] divisor_q;
  logic [W-1:0] quot_q;
  logic [W-1:0] rem_q;
  logic         done_q;
  logic         out_valid_q;
  logic [W-1:0] read_data_q, read_data_d;
  logic [W:0]   part_rem;
  logic [W:0]   trial;
  logic         fits;
  logic         is_write;

  assign is_write = (kind_i == dra_pkg::KIND_WRITE);

  assign sts_o.div_req  = is_write && (reg_offset_i == dra_pkg::OFS_DIVISOR);
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  // restoring step: shift in next dividend bit, subtract if it fits
  assign part_rem = {rem_q, quot_q[W-1]};
  assign trial    = part_rem - {1'b0, divisor_q};
  assign fits     = !trial[W];

  // read-data for the accepted word
  always_comb begin
    read_data_d = '0;
    if (!is_write) begin
      case (reg_offset_i)
        dra_pkg::OFS_QUOTIENT:  read_data_d = quot_q;
        dra_pkg::OFS_REMAINDER: read_data_d = rem_q;
        dra_pkg::OFS_READY:     read_data_d = dra_pkg::READY_VALUE;
        dra_pkg::OFS_DONE:      read_data_d = {{(W-1){1'b0}}, done_q};
        default:                read_data_d = '0;
      endcase
    end
  end

  // register stores and iterative division
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dividend_q <= '0;
      divisor_q  <= '0;
      quot_q     <= '0;
      rem_q      <= '0;
      done_q     <= 1'b0;
    end else if (cmd_i.step) begin
      quot_q <= {quot_q[W-2:0], fits};
      rem_q  <= fits ? trial[W-1:0] : part_rem[W-1:0];
      if (cmd_i.last) begin
        done_q <= 1'b1;
      end
    end else if (cmd_i.accept && is_write) begin
      case (reg_offset_i)
        dra_pkg::OFS_DIVIDEND: dividend_q <= write_data_i;
        dra_pkg::OFS_DIVISOR: begin
          divisor_q <= write_data_i;
          quot_q    <= dividend_q;
          rem_q     <= '0;
        end
        dra_pkg::OFS_DONE: done_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      read_data_q <= read_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> out_valid_q)
    else $error("accepted word gave no result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts_o.out_busy && !cmd_i.accept) |=> out_valid_q && $stable(read_data_q))
    else $error("stalled result lost or changed");

  a_done_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.last |=> done_q)
    else $error("done not set after division");
`endif

endmodule

@@ rtl/divider_register_accelerator_unit.sv @@
// Unsigned divider behind a small register window.
// Input channel: one bus access per word (kind_i, reg_offset_i,
// write_data_i), taken when in_valid_i is high and in_stall_o is low.
// Output channel: one read_data_o word per access, offered with
// out_valid_o and taken when out_stall_i is low; writes return zero.
// Offsets: 0 dividend, 1 divisor (starts division), 2 quotient,
// 3 remainder, 4 ready (reads 1), 5 done (write clears it).
// The result of any access is registered and offered in the cycle
// after it is taken. Throughput: one access per cycle while the result
// register is not stalled, except that a divisor write runs a restoring
// division of one quotient bit per cycle and holds off further accesses
// until it ends. The single datapath subtractor sets the division speed.
// Division by zero yields an all-ones quotient and the dividend as
// remainder.
// Reset clears dividend, quotient, remainder and done and empties the
// result register. A stalled receiver holds the result register; one more
// access can be taken meanwhile only when the result register drains.
module divider_register_accelerator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [2:0]                     reg_offset_i,
  input  logic [dra_pkg::DATA_WIDTH-1:0] write_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dra_pkg::DATA_WIDTH-1:0] read_data_o
);

  dra_pkg::cmd_t cmd;
  dra_pkg::sts_t sts;

  // sequencing of accesses and division steps
  dra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // registers, divider and result register
  dra_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_i),
    .reg_offset_i (reg_offset_i),
    .write_data_i (write_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o)
  );

endmodule
